[hdl/bls_pkg.sv]
// Shared constants, types and controller states of the line stepper.
`default_nettype none
package bls_pkg;

  localparam int unsigned COORD_W        = 6;
  localparam int unsigned COLOR_W        = 32;
  localparam int unsigned COORD_BITS_DEF = 6;
  localparam int unsigned ERR_W_MAX      = COORD_W + 2;
  localparam int unsigned QUEUE_DEPTH    = 2;

  typedef struct packed {
    logic [COORD_W-1:0]          start_x;
    logic [COORD_W-1:0]          start_y;
    logic [COORD_W-1:0]          end_x;
    logic [COORD_W-1:0]          end_y;
    logic [COORD_W-1:0]          abs_dx;
    logic [COORD_W-1:0]          abs_dy;
    logic                        neg_x;
    logic                        neg_y;
    logic signed [ERR_W_MAX-1:0] err;
    logic [COLOR_W-1:0]          color;
  } line_job_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } back_state_e;

endpackage
`default_nettype wire

[hdl/bls_if.sv]
// Valid/ready channel interfaces for line commands and pixel transfers.
`default_nettype none
interface bls_cmd_if;
  import bls_pkg::*;
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] start_x;
  logic [COORD_W-1:0] start_y;
  logic [COORD_W-1:0] end_x;
  logic [COORD_W-1:0] end_y;
  logic [COLOR_W-1:0] line_color;

  modport source (output valid, start_x, start_y, end_x, end_y, line_color, input ready);
  modport sink   (input valid, start_x, start_y, end_x, end_y, line_color, output ready);
endinterface

interface bls_pix_if;
  import bls_pkg::*;
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] pixel_x;
  logic [COORD_W-1:0] pixel_y;
  logic [COLOR_W-1:0] pixel_color;
  logic               last_pixel;

  modport source (output valid, pixel_x, pixel_y, pixel_color, last_pixel, input ready);
  modport sink   (input valid, pixel_x, pixel_y, pixel_color, last_pixel, output ready);
endinterface
`default_nettype wire

[hdl/bls_front.sv]
// Command front end: takes a line command and derives extents, directions and start error.
`default_nettype none
module bls_front #(
  parameter int unsigned COORD_BITS = bls_pkg::COORD_BITS_DEF
) (
  bls_cmd_if.sink           cmd_i,
  input  logic              full_i,
  output logic              push_o,
  output bls_pkg::line_job_t job_o
);
  import bls_pkg::*;

  logic [COORD_BITS-1:0]        sx, sy, ex, ey;
  logic [COORD_BITS-1:0]        dx, dy;
  logic signed [COORD_BITS+1:0] err_s;

  assign sx = cmd_i.start_x[COORD_BITS-1:0];
  assign sy = cmd_i.start_y[COORD_BITS-1:0];
  assign ex = cmd_i.end_x[COORD_BITS-1:0];
  assign ey = cmd_i.end_y[COORD_BITS-1:0];

  assign dx    = (sx > ex) ? (sx - ex) : (ex - sx);
  assign dy    = (sy > ey) ? (sy - ey) : (ey - sy);
  assign err_s = $signed({2'b00, dx}) - $signed({2'b00, dy});

  assign cmd_i.ready = !full_i;
  assign push_o      = cmd_i.valid && !full_i;

  always_comb begin
    job_o.start_x = COORD_W'(sx);
    job_o.start_y = COORD_W'(sy);
    job_o.end_x   = COORD_W'(ex);
    job_o.end_y   = COORD_W'(ey);
    job_o.abs_dx  = COORD_W'(dx);
    job_o.abs_dy  = COORD_W'(dy);
    job_o.neg_x   = !(sx < ex);
    job_o.neg_y   = !(sy < ey);
    job_o.err     = ERR_W_MAX'(err_s);
    job_o.color   = cmd_i.line_color;
  end

endmodule
`default_nettype wire

[hdl/bls_queue.sv]
// Small job queue between the command front end and the pixel walker.
`default_nettype none
module bls_queue #(
  parameter int unsigned DEPTH = bls_pkg::QUEUE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  bls_pkg::line_job_t job_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               empty_o,
  output bls_pkg::line_job_t job_o
);
  import bls_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  line_job_t        mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign job_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule
`default_nettype wire

[hdl/bls_back.sv]
// Pixel walker: steps one Bresenham pixel per cycle into an output register while that register is free.
`default_nettype none
module bls_back #(
  parameter int unsigned COORD_BITS = bls_pkg::COORD_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               empty_i,
  input  bls_pkg::line_job_t job_i,
  output logic               pop_o,
  bls_pix_if.source          pix_o
);
  import bls_pkg::*;

  localparam int unsigned CB    = COORD_BITS;
  localparam int unsigned ERR_W = COORD_BITS + 2;

  back_state_e state_q, state_d;

  logic [CB-1:0]           walk_x_q, walk_y_q, tgt_x_q, tgt_y_q;
  logic [CB-1:0]           dx_q, dy_q, cnt_q;
  logic [1:0]              neg_q;
  logic signed [ERR_W-1:0] err_q;
  logic [COLOR_W-1:0]      color_q;

  logic               out_valid_q, out_valid_d;
  logic [COORD_W-1:0] out_x_q, out_y_q;
  logic [COLOR_W-1:0] out_color_q;
  logic               out_last_q;

  logic                    slot_free, at_end, last, emit, load;
  logic signed [ERR_W:0]   e2, dx_w, dy_w;
  logic signed [ERR_W-1:0] dx_e, dy_e, err_d;
  logic                    step_x, step_y;
  logic [CB-1:0]           walk_x_d, walk_y_d;

  assign slot_free = !out_valid_q || pix_o.ready;
  assign at_end    = (walk_x_q == tgt_x_q) && (walk_y_q == tgt_y_q);
  assign last      = at_end || (cnt_q == '1);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (!empty_i) state_d = ST_RUN;
      ST_RUN:  if (slot_free && last) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    load = 1'b0;
    emit = 1'b0;
    unique case (state_q)
      ST_IDLE: load = !empty_i;
      ST_RUN:  emit = slot_free;
      default: ;
    endcase
  end

  assign pop_o = load;

  // Doubled error against the two extents; both axes may step.
  always_comb begin
    e2     = {err_q, 1'b0};
    dx_w   = $signed({3'b000, dx_q});
    dy_w   = $signed({3'b000, dy_q});
    dx_e   = $signed({2'b00, dx_q});
    dy_e   = $signed({2'b00, dy_q});
    step_x = (e2 >= -dy_w);
    step_y = (e2 <= dx_w);
    err_d  = err_q - (step_x ? dy_e : '0) + (step_y ? dx_e : '0);
    walk_x_d = walk_x_q;
    walk_y_d = walk_y_q;
    if (step_x) walk_x_d = neg_q[0] ? walk_x_q - 1'b1 : walk_x_q + 1'b1;
    if (step_y) walk_y_d = neg_q[1] ? walk_y_q - 1'b1 : walk_y_q + 1'b1;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (pix_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      walk_x_q <= job_i.start_x[CB-1:0];
      walk_y_q <= job_i.start_y[CB-1:0];
      tgt_x_q  <= job_i.end_x[CB-1:0];
      tgt_y_q  <= job_i.end_y[CB-1:0];
      dx_q     <= job_i.abs_dx[CB-1:0];
      dy_q     <= job_i.abs_dy[CB-1:0];
      neg_q    <= {job_i.neg_y, job_i.neg_x};
      err_q    <= job_i.err[ERR_W-1:0];
      color_q  <= job_i.color;
      cnt_q    <= '0;
    end else if (emit && !last) begin
      walk_x_q <= walk_x_d;
      walk_y_q <= walk_y_d;
      err_q    <= err_d;
      cnt_q    <= cnt_q + 1'b1;
    end
    if (emit) begin
      out_x_q     <= COORD_W'(walk_x_q);
      out_y_q     <= COORD_W'(walk_y_q);
      out_color_q <= color_q;
      out_last_q  <= last;
    end
  end

  assign pix_o.valid       = out_valid_q;
  assign pix_o.pixel_x     = out_x_q;
  assign pix_o.pixel_y     = out_y_q;
  assign pix_o.pixel_color = out_color_q;
  assign pix_o.last_pixel  = out_last_q;

endmodule
`default_nettype wire

[hdl/bresenham_line_stepper_unit.sv]
// Bresenham line stepper: line commands in, one pixel transfer per line pixel out.
//
// cmd_i carries a line command (start_x/y, end_x/y, line_color); pix_o carries
// pixels (pixel_x/y, pixel_color, last_pixel), both valid/ready.
// The front end derives extents and direction and writes the job into a
// two-entry queue; cmd_i.ready is high whenever that queue has room.
// The walker pops a job, then produces one pixel per cycle into an output
// register while that register is free; a line has N = max(|dx|,|dy|) + 1
// pixels. When the walker is free, a command passes the queue, the walker's
// job registers and the output register before its first pixel appears.
// last_pixel marks the end point of each line.
// When pix_o.valid is high and pix_o.ready is low the output register holds and the walker waits;
// commands keep being taken until the queue is full.
// Reset empties the queue, stops the walker and drops pix_o.valid.
`default_nettype none
module bresenham_line_stepper_unit #(
  parameter int unsigned COORD_BITS = bls_pkg::COORD_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bls_cmd_if.sink   cmd_i,
  bls_pix_if.source pix_o
);
  import bls_pkg::*;

  line_job_t push_job, pop_job;
  logic      push, pop, full, empty;

  bls_front #(.COORD_BITS(COORD_BITS)) u_front (
    .cmd_i  (cmd_i),
    .full_i (full),
    .push_o (push),
    .job_o  (push_job)
  );

  bls_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .job_o   (pop_job)
  );

  bls_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .job_i   (pop_job),
    .pop_o   (pop),
    .pix_o   (pix_o)
  );

endmodule
`default_nettype wire

[hdl/bls_checker.sv]
// Port-level checker for the line stepper, bound to the top level.
`default_nettype none
module bls_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       cmd_valid_i,
  input logic                       cmd_ready_i,
  input logic                       pix_valid_i,
  input logic                       pix_ready_i,
  input logic [bls_pkg::COORD_W-1:0] pix_x_i,
  input logic [bls_pkg::COORD_W-1:0] pix_y_i,
  input logic [bls_pkg::COLOR_W-1:0] pix_color_i,
  input logic                       pix_last_i
);
  import bls_pkg::*;

  logic               cmd_xfer, pix_xfer;
  logic [2:0]         pending_q;
  logic               in_run_q;
  logic [COORD_W-1:0] prev_x_q, prev_y_q;
  logic [COORD_W-1:0] dist_x, dist_y;

  assign cmd_xfer = cmd_valid_i && cmd_ready_i;
  assign pix_xfer = pix_valid_i && pix_ready_i;
  assign dist_x   = (pix_x_i > prev_x_q) ? pix_x_i - prev_x_q : prev_x_q - pix_x_i;
  assign dist_y   = (pix_y_i > prev_y_q) ? pix_y_i - prev_y_q : prev_y_q - pix_y_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
      in_run_q  <= 1'b0;
    end else begin
      pending_q <= pending_q + 3'(cmd_xfer) - 3'(pix_xfer && pix_last_i);
      if (pix_xfer) in_run_q <= !pix_last_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_xfer) begin
      prev_x_q <= pix_x_i;
      prev_y_q <= pix_y_i;
    end
  end

  a_pix_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_valid_i && !pix_ready_i |=> pix_valid_i && $stable(pix_x_i) && $stable(pix_y_i)
      && $stable(pix_color_i) && $stable(pix_last_i))
    else $error("pixel changed while stalled");

  a_no_orphan_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_valid_i |-> pending_q != 3'd0)
    else $error("pixel without an open line command");

  a_adjacent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_xfer && in_run_q |-> (dist_x <= COORD_W'(1)) && (dist_y <= COORD_W'(1))
      && ((dist_x != '0) || (dist_y != '0)))
    else $error("consecutive pixels of a line are not neighbors");

endmodule

bind bresenham_line_stepper_unit bls_checker u_bls_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cmd_valid_i (cmd_i.valid),
  .cmd_ready_i (cmd_i.ready),
  .pix_valid_i (pix_o.valid),
  .pix_ready_i (pix_o.ready),
  .pix_x_i     (pix_o.pixel_x),
  .pix_y_i     (pix_o.pixel_y),
  .pix_color_i (pix_o.pixel_color),
  .pix_last_i  (pix_o.last_pixel)
);
`default_nettype wire
